>>> sv/spr_pkg.sv
// Shared constants, codes and types of the shape point raster.
package spr_pkg;

  localparam int MAX_POINTS_DEF  = 256;
  localparam int CANVAS_SIZE_DEF = 64;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_RENDER = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_DOT   = 2'd0;
  localparam logic [1:0] KIND_HLINE = 2'd1;
  localparam logic [1:0] KIND_VLINE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_RENDER = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
  } pt_op_t;

endpackage

>>> sv/spr_if.sv
// Channel interfaces for shape items in and row results out.
interface spr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [1:0]         shape_kind;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [7:0]         length;

  modport source (output valid, action, shape_kind, x, y, length, input ready);
  modport sink   (input valid, action, shape_kind, x, y, length, output ready);
endinterface

interface spr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_bits;
  logic [5:0]  row_index;
  logic [6:0]  row_width;
  logic [1:0]  status;
  logic        points_dropped;
  logic        last;

  modport source (output valid, row_bits, row_index, row_width, status, points_dropped,
                  last, input ready);
  modport sink   (input valid, row_bits, row_index, row_width, status, points_dropped,
                  last, output ready);
endinterface

>>> sv/shape_point_raster_top.sv
// Top level of the shape point raster: shape items in, canvas rows out.
// An add is expanded in the front end into n points of the shape, one point per cycle while the queue accepts.
// In the back end a render clears h rows, does a read-modify-write of one canvas row per
// stored point, and then sends the h rows out.
// Synchronous reset empties the point store, zeroes the bounding box and the drop flag.
module shape_point_raster_top
  import spr_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int CANVAS_SIZE = CANVAS_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spr_in_if.sink    shape_in,
  spr_out_if.source row_out
);

  // Ops from the front end travel through a short queue, so the front end keeps accepting and
  // expanding shapes, until the queue fills, while the back end paints or waits on a row transfer.
  logic   push_valid;
  logic   push_ready;
  pt_op_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  pt_op_t pop_data;

  // The front end turns each line into one point op per cycle while the queue accepts, stepping the
  // coordinate with 16-bit wrap, and passes render and clear as single ops.
  spr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .shape_in   (shape_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  spr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // The back end owns the point store and canvas memories. Ops are taken in order,
  // so every status and row result sees the drop flag as it stood at the render.
  spr_back #(
    .MAX_POINTS  (MAX_POINTS),
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .row_out   (row_out)
  );

endmodule

>>> sv/spr_front.sv
// Front end: accepts shape items and expands them into point, render and clear ops.
module spr_front
  import spr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  spr_in_if.sink shape_in,
  output logic   push_valid,
  input  logic   push_ready,
  output pt_op_t push_data
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PUSH = 2'b10
  } fstate_t;

  fstate_t     state;
  pt_op_t      cur;
  logic [1:0]  kind;
  logic [7:0]  remain;
  logic        accept;
  logic        go;
  op_t         go_op;
  logic [7:0]  go_count;

  assign shape_in.ready = (state == F_IDLE);
  assign accept         = shape_in.valid && shape_in.ready;
  assign push_valid     = (state == F_PUSH);
  assign push_data      = cur;

  always_comb begin
    go       = 1'b0;
    go_op    = OP_POINT;
    go_count = 8'd1;
    unique case (shape_in.action)
      ACT_ADD: begin
        case (shape_in.shape_kind)
          KIND_DOT: go = 1'b1;
          KIND_HLINE, KIND_VLINE: begin
            go       = 1'b1;
            go_count = (shape_in.length <= 8'd1) ? 8'd1 : shape_in.length;
          end
          default: go = 1'b0;
        endcase
      end
      ACT_RENDER: begin
        go    = 1'b1;
        go_op = OP_RENDER;
      end
      ACT_CLEAR: begin
        go    = 1'b1;
        go_op = OP_CLEAR;
      end
      default: go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && go) begin
            cur.op <= go_op;
            cur.x  <= shape_in.x;
            cur.y  <= shape_in.y;
            kind   <= shape_in.shape_kind;
            remain <= go_count;
            state  <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            if (remain == 8'd1) begin
              state <= F_IDLE;
            end else begin
              remain <= remain - 8'd1;
              if (kind == KIND_HLINE) cur.x <= cur.x - 16'd1;
              if (kind == KIND_VLINE) cur.y <= cur.y - 16'd1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> sv/spr_fifo.sv
// Short op queue between the front end and the back end.
module spr_fifo
  import spr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  pt_op_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output pt_op_t rd_data
);

  localparam int PW = $clog2(FIFO_DEPTH);

  pt_op_t        entries [FIFO_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (cnt != (PW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = entries[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) entries[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + PW'(1);
      if (do_rd) rp <= rp + PW'(1);
      if (do_wr && !do_rd) cnt <= cnt + (PW+1)'(1);
      else if (do_rd && !do_wr) cnt <= cnt - (PW+1)'(1);
    end
  end

endmodule

>>> sv/spr_back.sv
// Back end: point store, bounding box, canvas painting and row emission.
module spr_back
  import spr_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int CANVAS_SIZE = CANVAS_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  pt_op_t    pop_data,
  spr_out_if.source row_out
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = (CANVAS_SIZE > 1) ? $clog2(CANVAS_SIZE) : 1;
  localparam logic [16:0] CANVAS_LIM = 17'(CANVAS_SIZE);

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_CHECK = 9'b000000010,
    B_STAT  = 9'b000000100,
    B_CLR   = 9'b000001000,
    B_PRD   = 9'b000010000,
    B_PCALC = 9'b000100000,
    B_PWR   = 9'b001000000,
    B_RRD   = 9'b010000000,
    B_ROUT  = 9'b100000000
  } bstate_t;

  bstate_t            state;
  logic [31:0]        point_store [MAX_POINTS];
  logic [CANVAS_SIZE-1:0] canvas  [CANVAS_SIZE];
  logic [CNTW-1:0]    point_count;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  logic               drop_flag;
  logic [CNTW-1:0]    pidx;
  logic [6:0]         ridx;
  logic [6:0]         w_reg, h_reg;
  logic [1:0]         status_reg;
  logic [CW-1:0]      row_r, col_r;
  logic [31:0]        store_q;
  logic [CANVAS_SIZE-1:0] canvas_q;

  logic               pop;
  logic               full;
  logic signed [15:0] px, py, sx, sy;
  logic [16:0]        w_full, h_full;
  logic [16:0]        row_c, col_c;
  logic               last_row;
  logic               cv_wr, cv_rd;
  logic [CW-1:0]      cv_waddr, cv_raddr;
  logic [CANVAS_SIZE-1:0] cv_wdata;

  assign pop_ready = (state == B_IDLE);
  assign pop       = pop_valid && pop_ready;
  assign full      = (point_count == CNTW'(MAX_POINTS));
  assign px        = $signed(pop_data.x);
  assign py        = $signed(pop_data.y);
  assign sx        = $signed(store_q[15:0]);
  assign sy        = $signed(store_q[31:16]);

  assign w_full = {max_x[15], max_x} - {min_x[15], min_x} + 17'd1;
  assign h_full = {max_y[15], max_y} - {min_y[15], min_y} + 17'd1;
  assign row_c  = {max_y[15], max_y} - {sy[15], sy};
  assign col_c  = {sx[15], sx} - {min_x[15], min_x};
  assign last_row = (ridx == 7'(h_reg - 7'd1));

  always_ff @(posedge clk) begin
    if (pop && pop_data.op == OP_POINT && !full)
      point_store[point_count[AW-1:0]] <= {pop_data.y, pop_data.x};
    if (state == B_PRD) store_q <= point_store[pidx[AW-1:0]];
  end

  always_comb begin
    cv_wr    = (state == B_CLR) || (state == B_PWR);
    cv_waddr = (state == B_CLR) ? ridx[CW-1:0] : row_r;
    cv_wdata = (state == B_CLR) ? '0 : (canvas_q | (CANVAS_SIZE'(1) << col_r));
    cv_rd    = (state == B_PCALC) || (state == B_RRD);
    cv_raddr = (state == B_PCALC) ? row_c[CW-1:0] : ridx[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cv_wr) canvas[cv_waddr] <= cv_wdata;
    if (cv_rd) canvas_q <= canvas[cv_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      point_count <= '0;
      min_x       <= '0;
      max_x       <= '0;
      min_y       <= '0;
      max_y       <= '0;
      drop_flag   <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            case (pop_data.op)
              OP_POINT: begin
                if (full) begin
                  drop_flag <= 1'b1;
                end else begin
                  if (point_count == '0) begin
                    min_x <= px;
                    max_x <= px;
                    min_y <= py;
                    max_y <= py;
                  end else begin
                    if (px < min_x) min_x <= px;
                    if (px > max_x) max_x <= px;
                    if (py < min_y) min_y <= py;
                    if (py > max_y) max_y <= py;
                  end
                  point_count <= point_count + CNTW'(1);
                end
              end
              OP_CLEAR: begin
                point_count <= '0;
                min_x       <= '0;
                max_x       <= '0;
                min_y       <= '0;
                max_y       <= '0;
                drop_flag   <= 1'b0;
              end
              OP_RENDER: state <= B_CHECK;
              default: state <= B_IDLE;
            endcase
          end
        end
        B_CHECK: begin
          if (point_count == '0) begin
            status_reg <= STATUS_EMPTY;
            state      <= B_STAT;
          end else if (w_full > CANVAS_LIM || h_full > CANVAS_LIM) begin
            status_reg <= STATUS_OVERSIZE;
            state      <= B_STAT;
          end else begin
            status_reg <= STATUS_OK;
            w_reg      <= w_full[6:0];
            h_reg      <= h_full[6:0];
            ridx       <= '0;
            pidx       <= '0;
            state      <= B_CLR;
          end
        end
        B_STAT: begin
          if (row_out.ready) state <= B_IDLE;
        end
        B_CLR: begin
          if (last_row) begin
            ridx  <= '0;
            state <= B_PRD;
          end else begin
            ridx <= ridx + 7'd1;
          end
        end
        B_PRD: state <= B_PCALC;
        B_PCALC: begin
          row_r <= row_c[CW-1:0];
          col_r <= col_c[CW-1:0];
          state <= B_PWR;
        end
        B_PWR: begin
          if (pidx == CNTW'(point_count - CNTW'(1))) begin
            state <= B_RRD;
          end else begin
            pidx  <= pidx + CNTW'(1);
            state <= B_PRD;
          end
        end
        B_RRD: state <= B_ROUT;
        B_ROUT: begin
          if (row_out.ready) begin
            if (last_row) begin
              state <= B_IDLE;
            end else begin
              ridx  <= ridx + 7'd1;
              state <= B_RRD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign row_out.valid          = (state == B_STAT) || (state == B_ROUT);
  assign row_out.row_bits       = (state == B_ROUT) ? 64'(canvas_q) : 64'd0;
  assign row_out.row_index      = (state == B_ROUT) ? ridx[5:0] : 6'd0;
  assign row_out.row_width      = (state == B_ROUT) ? w_reg : 7'd0;
  assign row_out.status         = status_reg;
  assign row_out.points_dropped = drop_flag;
  assign row_out.last           = (state == B_STAT) || last_row;

endmodule
